>>> design/mtri_pkg.sv
// Shared types and constants for the motor throttle ramp interlock.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package mtri_pkg;

  localparam int unsigned STICK_W = 11;
  localparam int unsigned DUTY_W  = 8;

  // Full-scale stick reading; anything above saturates to this
  localparam logic [STICK_W-1:0] STICK_FULL = 11'd1024;

  typedef enum logic [1:0] {
    CMD_THROTTLE = 2'd0,
    CMD_DIR      = 2'd1,
    CMD_BLOCK    = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e               command;
    logic [STICK_W-1:0] stick;
    logic               low_gear;
    logic               ramp_due;
    logic               dir_request;
  } item_t;

  typedef struct packed {
    logic [DUTY_W-1:0] forward_duty;
    logic [DUTY_W-1:0] backward_duty;
    logic              direction_forward;
    logic              is_blocked;
    logic              direction_accepted;
  } result_t;

endpackage

`default_nettype wire

>>> design/motor_throttle_ramp_interlock.sv
// Top level of the motor throttle ramp interlock: input register, state update,
// result register and the motor_ready register. Depends on mtri_pkg, mtri_state.
//
//  channel  direction  handshake                 payload
//  -------  ---------  ------------------------  ------------------------------
//  in       into block in_valid_i / in_stall_o   command, stick, low_gear,
//                                                ramp_due, dir_request
//  out      from block out_valid_o / out_stall_i forward_duty, backward_duty,
//                                                direction_forward, is_blocked,
//                                                direction_accepted
//  cfg      into block cfg_valid_i / cfg_ready_o cfg_data_i (motor_ready)
//
// One item per cycle sustained while out_stall_i is low.
// The input register feeds the state update, which loads the result register in
// the same cycle; the state registers advance only on that move.
// A stall on the output holds the result register and, once the input register is
// also full, raises in_stall_o. Reset: duty zero, forward, stopped, blocked, motor
// not ready, both stages empty. cfg_ready_o is always high.
`default_nettype none

module motor_throttle_ramp_interlock
  import mtri_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,

  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         command_i,
  input  wire logic [STICK_W-1:0] stick_i,
  input  wire logic               low_gear_i,
  input  wire logic               ramp_due_i,
  input  wire logic               dir_request_i,

  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic      [DUTY_W-1:0]  forward_duty_o,
  output logic      [DUTY_W-1:0]  backward_duty_o,
  output logic                    direction_forward_o,
  output logic                    is_blocked_o,
  output logic                    direction_accepted_o,

  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic               cfg_data_i
);

  logic    in_valid_q;
  item_t   item_q;
  logic    out_valid_q;
  result_t res_q, res_d;
  logic    motor_ready_q;
  logic    advance;
  logic    fire;

  // Result register is free when empty or being drained this cycle
  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign cfg_ready_o = 1'b1;

  // Hold the input item while the stage ahead is blocked
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      item_q.command     <= cmd_e'(command_i);
      item_q.stick       <= stick_i;
      item_q.low_gear    <= low_gear_i;
      item_q.ramp_due    <= ramp_due_i;
      item_q.dir_request <= dir_request_i;
    end
  end

  // Configuration transfer: only bit 0 of the write data matters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motor_ready_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      motor_ready_q <= cfg_data_i;
    end
  end

  mtri_state u_state (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .item_i        (item_q),
    .motor_ready_i (motor_ready_q),
    .result_o      (res_d)
  );

  // Advance the result register; drop its valid once the result is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign forward_duty_o       = res_q.forward_duty;
  assign backward_duty_o      = res_q.backward_duty;
  assign direction_forward_o  = res_q.direction_forward;
  assign is_blocked_o         = res_q.is_blocked;
  assign direction_accepted_o = res_q.direction_accepted;

endmodule

`default_nettype wire

>>> design/mtri_target.sv
// Stick to target duty mapping: saturate, scale by 255/1024, halve in low gear.
// Depends on mtri_pkg.
`default_nettype none

module mtri_target
  import mtri_pkg::*;
(
  input  wire logic [STICK_W-1:0] stick_i,
  input  wire logic               low_gear_i,
  output logic      [DUTY_W-1:0]  target_o
);

  logic [STICK_W-1:0]   stick_sat;
  logic [STICK_W+7:0]   scaled;
  logic [DUTY_W-1:0]    target_full;

  always_comb begin
    stick_sat   = (stick_i > STICK_FULL) ? STICK_FULL : stick_i;
    // stick * 255 as (stick << 8) - stick
    scaled      = {stick_sat, 8'd0} - {8'd0, stick_sat};
    target_full = scaled[STICK_W+6:STICK_W-1];
    target_o    = low_gear_i ? {1'b0, target_full[DUTY_W-1:1]} : target_full;
  end

endmodule

`default_nettype wire

>>> design/mtri_state.sv
// Motor state registers (duty, direction, stopped, block latch) and their update.
// Depends on mtri_pkg and mtri_target.
`default_nettype none

module mtri_state
  import mtri_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    fire_i,
  input  wire item_t   item_i,
  input  wire logic    motor_ready_i,
  output result_t      result_o
);

  logic [DUTY_W-1:0] duty_q, duty_d;
  logic              dir_fwd_q, dir_fwd_d;
  logic              stopped_q, stopped_d;
  logic              latch_q, latch_d;
  logic              accepted;
  logic              latch_thr;
  logic [STICK_W-1:0] stick_eff;
  logic [DUTY_W-1:0] target;

  // Latch clears on a zero stick; hold stick at zero while latched or not ready
  assign latch_thr = latch_q && (item_i.stick != '0);
  assign stick_eff = (latch_thr || !motor_ready_i) ? '0 : item_i.stick;

  mtri_target u_target (
    .stick_i    (stick_eff),
    .low_gear_i (item_i.low_gear),
    .target_o   (target)
  );

  always_comb begin
    duty_d    = duty_q;
    dir_fwd_d = dir_fwd_q;
    stopped_d = stopped_q;
    latch_d   = latch_q;
    accepted  = 1'b0;
    case (item_i.command)
      CMD_THROTTLE: begin
        latch_d   = latch_thr;
        stopped_d = (duty_q == '0);
        if (item_i.ramp_due) begin
          if (target > duty_q) begin
            duty_d = duty_q + 1'b1;
          end else if (target < duty_q) begin
            duty_d = duty_q - 1'b1;
          end
        end
      end
      CMD_DIR: begin
        if (stopped_q) begin
          dir_fwd_d = item_i.dir_request;
          accepted  = 1'b1;
        end
      end
      CMD_BLOCK: begin
        latch_d = 1'b1;
      end
      default: begin
      end
    endcase

    result_o.forward_duty       = dir_fwd_d ? duty_d : '0;
    result_o.backward_duty      = dir_fwd_d ? '0 : duty_d;
    result_o.direction_forward  = dir_fwd_d;
    result_o.is_blocked         = latch_d;
    result_o.direction_accepted = accepted;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q    <= '0;
      dir_fwd_q <= 1'b1;
      stopped_q <= 1'b1;
      latch_q   <= 1'b1;
    end else if (fire_i) begin
      duty_q    <= duty_d;
      dir_fwd_q <= dir_fwd_d;
      stopped_q <= stopped_d;
      latch_q   <= latch_d;
    end
  end

endmodule

`default_nettype wire

>>> design/mtri_checker.sv
// Port-level checks on the motor throttle ramp interlock, bound to the top level.
// Depends on mtri_pkg and motor_throttle_ramp_interlock.
`default_nettype none

module mtri_checker
  import mtri_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic [DUTY_W-1:0] forward_duty_o,
  input wire logic [DUTY_W-1:0] backward_duty_o,
  input wire logic              direction_forward_o,
  input wire logic              direction_accepted_o
);

  logic xfer;
  assign xfer = out_valid_o && !out_stall_i;

  // Only the channel of the current direction carries duty
  a_idle_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (direction_forward_o ? (backward_duty_o == '0)
                                         : (forward_duty_o == '0)))
    else $error("duty on the channel opposite to the direction");

  // Stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(forward_duty_o)
      && $stable(backward_duty_o) && $stable(direction_forward_o))
    else $error("stalled result changed");

  // Successive results in one direction differ by at most one ramp step
  a_ramp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && $past(xfer) && rst_ni && $past(rst_ni)
      && direction_forward_o == $past(direction_forward_o)
      |-> (forward_duty_o == $past(forward_duty_o)
        || forward_duty_o == $past(forward_duty_o) + 8'd1
        || forward_duty_o + 8'd1 == $past(forward_duty_o)))
    else $error("duty jumped by more than one step");

  // Direction flips only on an accepted request
  a_dir_flip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && $past(xfer) && $past(rst_ni)
      && direction_forward_o != $past(direction_forward_o)
      |-> direction_accepted_o)
    else $error("direction changed without an accepted request");

endmodule

bind motor_throttle_ramp_interlock mtri_checker u_mtri_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .out_valid_o          (out_valid_o),
  .out_stall_i          (out_stall_i),
  .forward_duty_o       (forward_duty_o),
  .backward_duty_o      (backward_duty_o),
  .direction_forward_o  (direction_forward_o),
  .direction_accepted_o (direction_accepted_o)
);

`default_nettype wire
